[sv/matrix_multiply_top_defines.svh]
// Assertion macros shared by the matrix multiply RTL.
// MM_ASSERT checks a property on every rising edge outside reset.
// MM_ASSERT_NEVER checks that a condition never holds outside reset.
`ifndef MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define MM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("matrix multiply assertion failed");
`define MM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("matrix multiply forbidden condition seen");
`else
`define MM_ASSERT(lbl, clk, rst_n, prop)
`define MM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[sv/mm_pkg.sv]
`default_nettype none

package mm_pkg;

    localparam int VALUE_W   = 32;
    localparam int ROWCOL_W  = 3;
    localparam int REQ_W     = 2;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W     = 64;
    localparam int FRAC_W    = 16;
    localparam int TERM_W    = ACC_W - FRAC_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WR_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MUL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic signed [ACC_W-1:0] Q_MAX      = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] Q_MIN      = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sh0000_0000_0000_8000;

    localparam logic signed [VALUE_W-1:0] SAT_POS = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] SAT_NEG = 32'sh8000_0000;

    typedef struct packed {
        logic [REQ_W-1:0]           op;
        logic [ROWCOL_W-1:0]        row;
        logic [ROWCOL_W-1:0]        col;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] rows_a;
        logic [CFG_W-1:0] inner_dim;
        logic [CFG_W-1:0] cols_b;
    } t_dims;

endpackage

`default_nettype wire

[sv/mm_in_if.sv]
`default_nettype none

interface mm_in_if;
    logic                               valid;
    logic                               ready;
    logic [mm_pkg::REQ_W-1:0]           req_type;
    logic [mm_pkg::ROWCOL_W-1:0]        row;
    logic [mm_pkg::ROWCOL_W-1:0]        col;
    logic signed [mm_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output req_type, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input req_type, input row, input col, input value,
                    output ready);
endinterface

`default_nettype wire

[sv/mm_out_if.sv]
`default_nettype none

interface mm_out_if;
    logic                               valid;
    logic                               ready;
    logic [mm_pkg::ROWCOL_W-1:0]        out_row;
    logic [mm_pkg::ROWCOL_W-1:0]        out_col;
    logic signed [mm_pkg::VALUE_W-1:0]  product;
    logic                               saturated;
    logic                               last;

    modport source (output valid, output out_row, output out_col, output product,
                    output saturated, output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input product,
                    input saturated, input last, output ready);
endinterface

`default_nettype wire

[sv/mm_front.sv]
`default_nettype none

module mm_front #(
    parameter int MAX_DIM = 8
) (
    mm_in_if.sink         i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output mm_pkg::t_cmd  o_cmd
);
    import mm_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int RC_W  = (CNT_W > ROWCOL_W) ? CNT_W : ROWCOL_W;

    logic [RC_W-1:0] row_ext;
    logic [RC_W-1:0] col_ext;
    logic            in_range;
    logic            keep;

    assign i_in.ready = !i_q_full;

    assign row_ext  = RC_W'(i_in.row);
    assign col_ext  = RC_W'(i_in.col);
    assign in_range = (row_ext < RC_W'(MAX_DIM)) && (col_ext < RC_W'(MAX_DIM));

    // drop unused codes and writes outside the stores
    always_comb begin
        case (i_in.req_type)
            REQ_WR_A, REQ_WR_B: keep = in_range;
            REQ_MUL:            keep = 1'b1;
            default:            keep = 1'b0;
        endcase
    end

    assign o_push      = i_in.valid && i_in.ready && keep;
    assign o_cmd.op    = i_in.req_type;
    assign o_cmd.row   = i_in.row;
    assign o_cmd.col   = i_in.col;
    assign o_cmd.value = i_in.value;

endmodule

`default_nettype wire

[sv/mm_queue.sv]
`default_nettype none
`include "matrix_multiply_top_defines.svh"

module mm_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mm_pkg::t_cmd  i_cmd,
    input  logic          i_pop,
    output mm_pkg::t_cmd  o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import mm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `MM_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `MM_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty)
    `MM_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))

endmodule

`default_nettype wire

[sv/mm_back.sv]
`default_nettype none
`include "matrix_multiply_top_defines.svh"

module mm_back #(
    parameter int MAX_DIM = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mm_pkg::t_dims  i_dims,
    input  logic           i_empty,
    input  mm_pkg::t_cmd   i_cmd,
    output logic           o_pop,
    mm_out_if.source       o_out
);
    import mm_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int RC_W  = (CNT_W > ROWCOL_W) ? CNT_W : ROWCOL_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // register value 0 acts as 1, values above MAX_DIM as MAX_DIM
    function automatic logic [IDX_W-1:0] last_idx(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] e;
        logic [CMP_W-1:0] d;
        logic [CMP_W-1:0] m;
        e = CMP_W'(v);
        if (e == '0) begin
            d = CMP_W'(1);
        end else if (e > CMP_W'(MAX_DIM)) begin
            d = CMP_W'(MAX_DIM);
        end else begin
            d = e;
        end
        m = d - CMP_W'(1);
        return m[IDX_W-1:0];
    endfunction

    logic signed [VALUE_W-1:0] mem_a [MAX_DIM][MAX_DIM];
    logic signed [VALUE_W-1:0] mem_b [MAX_DIM][MAX_DIM];

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [IDX_W-1:0]          r_i;
    logic [IDX_W-1:0]          r_j;
    logic [IDX_W-1:0]          r_k;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic signed [VALUE_W-1:0] r_a_q;
    logic signed [VALUE_W-1:0] r_b_q;
    logic signed [ACC_W-1:0]   r_prod;
    logic signed [TERM_W-1:0]  r_term;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    logic [ROWCOL_W-1:0]       r_out_row;
    logic [ROWCOL_W-1:0]       r_out_col;
    logic signed [VALUE_W-1:0] r_out_product;
    logic                      r_out_sat;
    logic                      r_out_last;

    logic [IDX_W-1:0]          nr_m1;
    logic [IDX_W-1:0]          nk_m1;
    logic [IDX_W-1:0]          nc_m1;
    logic [RC_W-1:0]           wr_row_ext;
    logic [RC_W-1:0]           wr_col_ext;
    logic [IDX_W-1:0]          wr_row;
    logic [IDX_W-1:0]          wr_col;
    logic [RC_W-1:0]           i_ext;
    logic [RC_W-1:0]           j_ext;
    logic                      wr_a;
    logic                      wr_b;
    logic                      start;
    logic                      out_load;
    logic                      elem_last;
    logic                      drained;
    logic signed [ACC_W-1:0]   rnd;
    logic                      sat_hi;
    logic                      sat_lo;

    assign nr_m1 = last_idx(i_dims.rows_a);
    assign nk_m1 = last_idx(i_dims.inner_dim);
    assign nc_m1 = last_idx(i_dims.cols_b);

    assign wr_row_ext = RC_W'(i_cmd.row);
    assign wr_col_ext = RC_W'(i_cmd.col);
    assign wr_row     = wr_row_ext[IDX_W-1:0];
    assign wr_col     = wr_col_ext[IDX_W-1:0];

    assign o_pop     = (r_state == ST_IDLE) && !i_empty;
    assign wr_a      = o_pop && (i_cmd.op == REQ_WR_A);
    assign wr_b      = o_pop && (i_cmd.op == REQ_WR_B);
    assign start     = o_pop && (i_cmd.op == REQ_MUL);
    assign out_load  = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);
    assign elem_last = (r_i == nr_m1) && (r_j == nc_m1);
    assign drained   = !(r_v1 || r_v2 || r_v3);

    always_comb begin
        case (r_state)
            ST_IDLE:  n_state = start ? ST_RUN : ST_IDLE;
            ST_RUN:   n_state = (r_k == nk_m1) ? ST_DRAIN : ST_RUN;
            ST_DRAIN: n_state = drained ? ST_EMIT : ST_DRAIN;
            ST_EMIT: begin
                if (out_load) begin
                    n_state = elem_last ? ST_IDLE : ST_RUN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == ST_RUN);
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            if (start) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end
            if (r_state == ST_RUN) begin
                r_k <= (r_k == nk_m1) ? '0 : r_k + 1'b1;
            end
            if (out_load) begin
                if (elem_last) begin
                    r_i <= '0;
                    r_j <= '0;
                end else if (r_j == nc_m1) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // element stores: one write and one read per cycle each
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[wr_row][wr_col] <= i_cmd.value;
        end
        r_a_q <= mem_a[r_i][r_k];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[wr_row][wr_col] <= i_cmd.value;
        end
        r_b_q <= mem_b[r_k][r_j];
    end

    // round half up: add one half, keep the floor of the shift
    assign rnd = r_prod + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        r_prod <= r_a_q * r_b_q;
        r_term <= rnd[ACC_W-1:FRAC_W];
        if (start || out_load) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + {{FRAC_W{r_term[TERM_W-1]}}, r_term};
        end
    end

    assign sat_hi = (r_acc > Q_MAX);
    assign sat_lo = (r_acc < Q_MIN);
    assign i_ext  = RC_W'(r_i);
    assign j_ext  = RC_W'(r_j);

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row     <= i_ext[ROWCOL_W-1:0];
            r_out_col     <= j_ext[ROWCOL_W-1:0];
            r_out_product <= sat_hi ? SAT_POS : (sat_lo ? SAT_NEG : r_acc[VALUE_W-1:0]);
            r_out_sat     <= sat_hi || sat_lo;
            r_out_last    <= elem_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_row   = r_out_row;
    assign o_out.out_col   = r_out_col;
    assign o_out.product   = r_out_product;
    assign o_out.saturated = r_out_sat;
    assign o_out.last      = r_out_last;

    `MM_ASSERT(a_k_rests_outside_run, i_clk, i_rst_n, (r_state != ST_RUN) |-> (r_k == '0))
    `MM_ASSERT(a_emit_after_drain, i_clk, i_rst_n, (r_state == ST_EMIT) |-> drained)
    `MM_ASSERT(a_issue_from_run, i_clk, i_rst_n, r_v1 |-> ($past(r_state) == ST_RUN))

endmodule

`default_nettype wire

[sv/matrix_multiply_top.sv]
// Matrix multiply C = A x B on signed Q16.16 elements.
// Input channel i_in (valid/ready): each beat is a request. Code write-A or
// write-B stores one element at (row, col); compute streams every element of
// C in row-major order on o_out, with last set on the final beat. Unused
// codes and writes outside the stores are accepted and dropped.
// Config port: i_cfg_we with i_cfg_idx selects rows_a, inner_dim or cols_b
// (reset 8 each); write only while the block is idle.
// Throughput: element writes are taken one per cycle while the sequencer is
// idle. A compute takes its beat from the queue, then runs one multiply-
// accumulate per cycle through the store read ports; each element of C passes
// through issue, read, multiply, round, accumulate and emit steps in order.
// Requests behind a compute wait in a short command queue, and i_in.ready
// drops only when that queue is full.
// Reset clears the queue, the sequencer and the output register; store
// contents are not cleared, and an element read before it was written is
// undefined. When the receiver holds o_out.ready low, the finished beat
// holds in the output register; the sequencer finishes the next element
// and then waits in its emit step until that register frees.
`default_nettype none

module matrix_multiply_top #(
    parameter int MAX_DIM     = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mm_in_if.sink                           i_in,
    mm_out_if.source                        o_out,
    input  logic                            i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mm_pkg::CFG_W-1:0]        i_cfg_data
);
    import mm_pkg::*;

    t_dims r_dims;
    t_cmd  push_cmd;
    t_cmd  head_cmd;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    // dimension registers; index 3 is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.rows_a    <= CFG_RESET;
            r_dims.inner_dim <= CFG_RESET;
            r_dims.cols_b    <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS_A:    r_dims.rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_dims.inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_dims.cols_b    <= i_cfg_data;
                default:       r_dims           <= r_dims;
            endcase
        end
    end

    // front: take requests, drop the ones with no effect
    mm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // command queue between front and back
    mm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: element stores, multiply-accumulate sequencer, output register
    mm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dims  (r_dims),
        .i_empty (q_empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[tb/mm_product_checker.sv]
module mm_product_checker #(
    parameter int MAX_DIM = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mm_in_if                              i_req,
    mm_out_if                             i_res,
    input  logic                          i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mm_pkg::CFG_W-1:0]      i_cfg_data,
    output int                            o_pending,
    output int                            o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import mm_pkg::*;

    typedef struct {
        logic [ROWCOL_W-1:0]       row;
        logic [ROWCOL_W-1:0]       col;
        logic signed [VALUE_W-1:0] product;
        logic                      saturated;
        logic                      last;
    } t_elem;

    logic signed [VALUE_W-1:0] a_mem [MAX_DIM][MAX_DIM];
    logic signed [VALUE_W-1:0] b_mem [MAX_DIM][MAX_DIM];
    t_dims                     dims;
    t_elem                     elems_due [$];
    int                        pending = 0;
    int                        fail_count = 0;

    assign o_pending    = pending;
    assign o_fail_count = fail_count;

    // zero acts as one, anything past the store size acts as the store size
    function automatic int eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // queue every element of C = A x B in row-major order
    function automatic void predict_product();
        int      nr;
        int      nk;
        int      nc;
        longint  acc;
        t_elem   e;
        nr = eff_dim(dims.rows_a);
        nk = eff_dim(dims.inner_dim);
        nc = eff_dim(dims.cols_b);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                acc = 0;
                // round each Q32.32 term half up to Q16.16, sum exactly
                for (int k = 0; k < nk; k++) begin
                    acc += (longint'(a_mem[i][k]) * longint'(b_mem[k][j]) + ROUND_HALF)
                           >>> FRAC_W;
                end
                e.saturated = 1'b0;
                if (acc > Q_MAX) begin
                    acc = Q_MAX;
                    e.saturated = 1'b1;
                end else if (acc < Q_MIN) begin
                    acc = Q_MIN;
                    e.saturated = 1'b1;
                end
                e.row     = ROWCOL_W'(i);
                e.col     = ROWCOL_W'(j);
                e.product = acc[VALUE_W-1:0];
                e.last    = (i == nr - 1) && (j == nc - 1);
                elems_due.push_back(e);
            end
        end
    endfunction

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_elem e;
        if (!i_rst_n) begin
            dims = '{rows_a: CFG_RESET, inner_dim: CFG_RESET, cols_b: CFG_RESET};
            elems_due.delete();
        end else begin
            // compare the result beat before adding anything new at this edge
            if (i_res.valid && i_res.ready) begin
                if (elems_due.size() == 0) begin
                    $display("%0t: unexpected beat, actual row %0d col %0d value %0d",
                             $time, i_res.out_row, i_res.out_col, i_res.product);
                    fail_count++;
                end else begin
                    e = elems_due.pop_front();
                    check_field("out_row", e.row, i_res.out_row);
                    check_field("out_col", e.col, i_res.out_col);
                    check_field("product", e.product, i_res.product);
                    check_field("saturated", e.saturated, i_res.saturated);
                    check_field("last", e.last, i_res.last);
                end
            end
            if (i_req.valid && i_req.ready) begin
                case (i_req.req_type)
                    REQ_WR_A: a_mem[i_req.row][i_req.col] = i_req.value;
                    REQ_WR_B: b_mem[i_req.row][i_req.col] = i_req.value;
                    REQ_MUL:  predict_product();
                    default: ;
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS_A:    dims.rows_a    = i_cfg_data;
                    CFG_INNER_DIM: dims.inner_dim = i_cfg_data;
                    CFG_COLS_B:    dims.cols_b    = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending = elems_due.size();
    end

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mm_pkg::*;

    localparam int MAX_DIM = 8;
    // the block accepts and drops this code
    localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
    // cycles to let queued writes drain once the last product beat is out
    localparam int DRAIN_CYCLES = 24;
    // long receiver hold-off so the command queue fills and ready drops
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 300;
    // hard stop, far beyond the slowest legal run
    localparam longint LIMIT_NS = 20_000_000;

    localparam logic signed [VALUE_W-1:0] CORNERS [6] = '{
        SAT_POS, SAT_NEG, 32'sh0000_0000, 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   pending;
    int                   fail_count;

    // shadow of which store entries hold a written value
    bit a_set [MAX_DIM][MAX_DIM];
    bit b_set [MAX_DIM][MAX_DIM];
    int eff_rows;
    int eff_inner;
    int eff_cols;
    int items_sent;
    // quiet turns off random idling on both sides
    bit quiet;
    // each increment asks the receiver for one long hold-off
    int hold_asks;

    mm_in_if  req_ch ();
    mm_out_if res_ch ();

    matrix_multiply_top #(
        .MAX_DIM (MAX_DIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mm_product_checker #(
        .MAX_DIM (MAX_DIM)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs or an element never shows up.
    initial begin
        #(LIMIT_NS);
        $display("matrix_multiply_top: mismatch");
        $finish;
    end

    // Receiver: drop ready at random, or hold it low for a long stretch when asked.
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= quiet || ($urandom_range(99) >= 9);
            end
        end
    end

    function automatic int clip_dim(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Mostly small Q16.16 values; corners and full-range words saturate and round.
    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(9))
            0:          return CORNERS[$urandom_range(5)];
            1, 2, 3, 4: return 32'($urandom_range(2097152)) - 32'd1048576;
            5:          return 32'($urandom_range(131072)) - 32'd65536;
            default:    return $urandom;
        endcase
    endfunction

    // Dimension register value: mostly small, sometimes zero, at or past the store size.
    function automatic logic [CFG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 6) return '0;
        if (r < 14) return CFG_W'($urandom_range(8, 15));
        return CFG_W'($urandom_range(1, 4));
    endfunction

    // Offer one request beat and hold it until the block takes it.
    task automatic send_req(input logic [REQ_W-1:0] op, input logic [ROWCOL_W-1:0] row,
                            input logic [ROWCOL_W-1:0] col,
                            input logic signed [VALUE_W-1:0] value);
        while (!quiet && $urandom_range(99) < 9) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.row      <= row;
        req_ch.col      <= col;
        req_ch.value    <= value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (op == REQ_WR_A) a_set[row][col] = 1'b1;
        if (op == REQ_WR_B) b_set[row][col] = 1'b1;
        if (op != REQ_NOP) items_sent++;
    endtask

    // Drop valid, wait for every product beat, then let queued writes drain.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all three dimension registers while the block is idle.
    task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
                            input logic [CFG_W-1:0] c);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ROWS_A;
        cfg_data <= r;
        @(posedge i_clk);
        cfg_idx  <= CFG_INNER_DIM;
        cfg_data <= k;
        @(posedge i_clk);
        cfg_idx  <= CFG_COLS_B;
        cfg_data <= c;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
        eff_rows  = clip_dim(r);
        eff_inner = clip_dim(k);
        eff_cols  = clip_dim(c);
    endtask

    // Write every entry the next product will read that was never written.
    task automatic fill_gaps();
        for (int i = 0; i < eff_rows; i++) begin
            for (int k = 0; k < eff_inner; k++) begin
                if (!a_set[i][k]) send_req(REQ_WR_A, 3'(i), 3'(k), rand_value());
            end
        end
        for (int k = 0; k < eff_inner; k++) begin
            for (int j = 0; j < eff_cols; j++) begin
                if (!b_set[k][j]) send_req(REQ_WR_B, 3'(k), 3'(j), rand_value());
            end
        end
    endtask

    // Row, column and value of a compute beat are don't-care; randomize them.
    task automatic request_product();
        fill_gaps();
        send_req(REQ_MUL, 3'($urandom), 3'($urandom), rand_value());
    endtask

    initial begin : stimulus
        int n;
        int pick;
        int phase;
        quiet     = 1'b0;
        hold_asks = 0;
        items_sent = 0;
        eff_rows  = MAX_DIM;
        eff_inner = MAX_DIM;
        eff_cols  = MAX_DIM;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_ROWS_A;
        cfg_data        <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_WR_A;
        req_ch.row      <= '0;
        req_ch.col      <= '0;
        req_ch.value    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a zero rows register behaves as one, so C is a single element.
        set_dims(4'd0, 4'd1, 4'd1);
        // both operands at the positive bound: clip high
        send_req(REQ_WR_A, 3'd0, 3'd0, SAT_POS);
        send_req(REQ_WR_B, 3'd0, 3'd0, SAT_POS);
        send_req(REQ_MUL, 3'd0, 3'd0, 32'sh0);
        // opposite bounds: clip low
        send_req(REQ_WR_B, 3'd0, 3'd0, SAT_NEG);
        send_req(REQ_MUL, 3'd7, 3'd7, SAT_NEG);
        // one half times one LSB: an exact tie rounds up to one LSB
        send_req(REQ_WR_A, 3'd0, 3'd0, 32'sh0000_8000);
        send_req(REQ_WR_B, 3'd0, 3'd0, 32'sh0000_0001);
        send_req(REQ_MUL, 3'd0, 3'd0, 32'sh0);
        // negative tie rounds up to zero
        send_req(REQ_WR_B, 3'd0, 3'd0, -32'sh0000_0001);
        send_req(REQ_MUL, 3'd0, 3'd0, 32'sh0);
        // unused code yields nothing
        send_req(REQ_NOP, 3'd5, 3'd2, SAT_POS);
        // far corner of both stores
        send_req(REQ_WR_A, 3'd7, 3'd7, SAT_NEG);
        send_req(REQ_WR_B, 3'd7, 3'd7, 32'sh0);
        // a columns register past the store size behaves as the store size
        set_dims(4'd1, 4'd1, 4'd12);
        request_product();

        // Random phases: new dimensions, a burst of writes and computes, a final compute.
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            quiet = (phase == 6 || phase == 7);
            if (phase == 0) begin
                // full-size product with the largest register value
                set_dims(4'd15, 4'd8, 4'd9);
            end else if (phase == 3 || phase == 10) begin
                set_dims(4'd3, 4'd3, 4'd3);
            end else begin
                set_dims(pick_dim(), pick_dim(), pick_dim());
            end
            if (phase == 3 || phase == 10) begin
                // Stall the receiver behind a compute and keep offering writes so the
                // command queue fills and the input stalls.
                fill_gaps();
                hold_asks++;
                send_req(REQ_MUL, 3'($urandom), 3'($urandom), rand_value());
                repeat (12) send_req(REQ_WR_A + REQ_W'($urandom_range(1)), 3'($urandom),
                                     3'($urandom), rand_value());
            end
            n = $urandom_range(6, 20);
            repeat (n) begin
                pick = $urandom_range(99);
                if (pick < 42) begin
                    send_req(REQ_WR_A, 3'($urandom), 3'($urandom), rand_value());
                end else if (pick < 84) begin
                    send_req(REQ_WR_B, 3'($urandom), 3'($urandom), rand_value());
                end else if (pick < 90) begin
                    send_req(REQ_NOP, 3'($urandom), 3'($urandom), rand_value());
                end else begin
                    request_product();
                end
            end
            request_product();
            phase++;
        end
        quiet = 1'b0;

        wait_idle();
        if (fail_count == 0) begin
            $display("matrix_multiply_top: match");
        end else begin
            $display("matrix_multiply_top: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/mm_pkg.sv
sv/mm_in_if.sv
sv/mm_out_if.sv
sv/mm_front.sv
sv/mm_queue.sv
sv/mm_back.sv
sv/matrix_multiply_top.sv
tb/mm_product_checker.sv
tb/testbench.sv
